@@ sv/tile_density_black_fill_assert.svh @@
// assertion macros for the tile density black fill block
// expects aclk and aresetn in the scope where the macros are used
`ifndef TILE_DENSITY_BLACK_FILL_ASSERT_SVH
`define TILE_DENSITY_BLACK_FILL_ASSERT_SVH

// same-cycle implication, off during reset
`define TDBF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define TDBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tdbf_pkg.sv @@
// shared types, codes and constants of the tile density black fill block
// no dependencies
package tdbf_pkg;

    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_TILE = 16;

    localparam int PIX_W    = 8;
    localparam int COORD_W  = 8;
    localparam int LIM_W    = 9;
    localparam int TSIZE_W  = 5;
    localparam int THR_W    = 9;
    localparam int ORG_W    = 10;
    localparam int TILES_W  = 13;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [TILES_W-1:0] TILES_MAX = {TILES_W{1'b1}};

    localparam logic [LIM_W-1:0]   RST_FRAME_ROWS = 9'd256;
    localparam logic [LIM_W-1:0]   RST_FRAME_COLS = 9'd256;
    localparam logic [TSIZE_W-1:0] RST_TILE_SIZE  = 5'd4;
    localparam logic [THR_W-1:0]   RST_FILL_THR   = 9'd1;

    localparam logic [1:0] REG_FRAME_ROWS = 2'd0;
    localparam logic [1:0] REG_FRAME_COLS = 2'd1;
    localparam logic [1:0] REG_TILE_SIZE  = 2'd2;
    localparam logic [1:0] REG_FILL_THR   = 2'd3;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [LIM_W-1:0]   frame_rows;
        logic [LIM_W-1:0]   frame_cols;
        logic [TSIZE_W-1:0] tile_size;
        logic [THR_W-1:0]   fill_threshold;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_TILE,
        ST_COUNT,
        ST_DRAIN,
        ST_DECIDE,
        ST_FILL,
        ST_DONE
    } state_t;

endpackage

@@ sv/tdbf_ram.sv @@
// generic single-clock ram, one write port and one read port with registered read
// no dependencies
module tdbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/tdbf_cfg.sv @@
// apb register file holding frame size, tile size and fill threshold
// depends on tdbf_pkg
module tdbf_cfg import tdbf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_FRAME_ROWS: cfg_next.frame_rows     = pwdata[LIM_W-1:0];
                REG_FRAME_COLS: cfg_next.frame_cols     = pwdata[LIM_W-1:0];
                REG_TILE_SIZE:  cfg_next.tile_size      = pwdata[TSIZE_W-1:0];
                REG_FILL_THR:   cfg_next.fill_threshold = pwdata[THR_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_rows     <= RST_FRAME_ROWS;
            cfg_reg.frame_cols     <= RST_FRAME_COLS;
            cfg_reg.tile_size      <= RST_TILE_SIZE;
            cfg_reg.fill_threshold <= RST_FILL_THR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_ROWS: prdata = APB_DW'(cfg_reg.frame_rows);
            REG_FRAME_COLS: prdata = APB_DW'(cfg_reg.frame_cols);
            REG_TILE_SIZE:  prdata = APB_DW'(cfg_reg.tile_size);
            REG_FILL_THR:   prdata = APB_DW'(cfg_reg.fill_threshold);
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/tile_density_black_fill.sv @@
// top level of the tile density black fill block: sequencer, tile walker, output register
// depends on tdbf_pkg, tdbf_ram, tdbf_cfg and tile_density_black_fill_assert.svh
//
// A write command's zero result beat is ready the cycle after accept; a read loads its
// beat in ST_READ from the registered frame ram read. A run walks the tiles with one
// shared address and counter step: each examined tile has a setup step in ST_TILE, a
// read of each pixel in ST_COUNT, ST_DRAIN and ST_DECIDE to end the count and compare,
// and a write of each pixel in ST_FILL if the tile is filled; each row of tiles adds a
// step in ST_TILE, and ST_DONE loads the result beat after the walk. With the ram's
// single read port and single write port, one pixel is touched per cycle. The frame
// ram has no reset; a pixel read before it was written returns whatever the ram holds.
`include "tile_density_black_fill_assert.svh"

module tile_density_black_fill import tdbf_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_TILE = DEF_MAX_TILE
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [COORD_W-1:0] s_row,
    input  logic [COORD_W-1:0] s_col,
    input  logic [PIX_W-1:0]   s_pixel_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PIX_W-1:0]   m_pixel_out,
    output logic [TILES_W-1:0] m_tiles_filled,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(MAX_TILE);
    localparam int TSW   = $clog2(MAX_TILE + 1);
    localparam int CNT_W = $clog2(MAX_TILE * MAX_TILE + 1);

    cfg_t cfg;

    state_t             state_reg, state_next;
    logic [ORG_W-1:0]   r0_reg, r0_next;
    logic [ORG_W-1:0]   c0_reg, c0_next;
    logic [TSW-1:0]     ts_reg, ts_next;
    logic [LIM_W-1:0]   rows_reg, rows_next;
    logic [LIM_W-1:0]   cols_reg, cols_next;
    logic [TW-1:0]      i_reg, i_next;
    logic [TW-1:0]      j_reg, j_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [TILES_W-1:0] filled_reg, filled_next;
    logic               in_store_reg, in_store_next;
    logic               m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]   m_pix_reg, m_pix_next;
    logic [TILES_W-1:0] m_tiles_reg, m_tiles_next;

    logic               s_accept;
    logic               in_store;
    logic [AW-1:0]      pix_addr;
    logic [TSW-1:0]     ts_sat;
    logic [LIM_W-1:0]   rows_sat;
    logic [LIM_W-1:0]   cols_sat;
    logic               row_end;
    logic               col_end;
    logic [AW-1:0]      tile_addr;
    logic               last_col;
    logic               last_row;
    logic               walk_last;
    logic [TW-1:0]      walk_i;
    logic [TW-1:0]      walk_j;
    logic [AW-1:0]      walk_addr;
    logic               fill_hit;
    logic               load_out;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [PIX_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [PIX_W-1:0]   ram_rdata;

    tdbf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    tdbf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pready   = 1'b1;
    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_accept = s_valid && s_ready;

    assign in_store = (32'(s_row) < 32'(MAX_ROWS)) && (32'(s_col) < 32'(MAX_COLS));
    assign pix_addr = AW'(32'(s_row) * 32'(MAX_COLS) + 32'(s_col));

    // run limits, clamped to the store and the largest tile
    assign ts_sat   = (32'(cfg.tile_size) > 32'(MAX_TILE)) ? TSW'(MAX_TILE)
                                                            : TSW'(cfg.tile_size);
    assign rows_sat = (32'(cfg.frame_rows) > 32'(MAX_ROWS)) ? LIM_W'(MAX_ROWS)
                                                             : cfg.frame_rows;
    assign cols_sat = (32'(cfg.frame_cols) > 32'(MAX_COLS)) ? LIM_W'(MAX_COLS)
                                                             : cfg.frame_cols;

    assign row_end   = (32'(r0_reg) + 32'(ts_reg)) >= 32'(rows_reg);
    assign col_end   = (32'(c0_reg) + 32'(ts_reg)) >= 32'(cols_reg);
    assign tile_addr = AW'(32'(r0_reg) * 32'(MAX_COLS) + 32'(c0_reg));

    // shared walker step over one tile, used for counting and for filling
    assign last_col  = (32'(j_reg) + 32'd1) == 32'(ts_reg);
    assign last_row  = (32'(i_reg) + 32'd1) == 32'(ts_reg);
    assign walk_last = last_col && last_row;
    assign walk_j    = last_col ? '0 : j_reg + 1'b1;
    assign walk_i    = last_col ? i_reg + 1'b1 : i_reg;
    assign walk_addr = last_col
        ? AW'(32'(addr_reg) + 32'(MAX_COLS) + 32'd1 - 32'(ts_reg))
        : addr_reg + 1'b1;

    assign fill_hit = 32'(cnt_reg) >= 32'(cfg.fill_threshold);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    priority case (s_command)
                        CMD_READ: state_next = ST_READ;
                        CMD_RUN:  state_next = (ts_sat == '0) ? ST_DONE : ST_TILE;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:   state_next = ST_IDLE;
            ST_TILE: begin
                if (row_end) begin
                    state_next = ST_DONE;
                end else if (!col_end) begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:  state_next = walk_last ? ST_DRAIN : ST_COUNT;
            ST_DRAIN:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = fill_hit ? ST_FILL : ST_TILE;
            ST_FILL:   state_next = walk_last ? ST_TILE : ST_FILL;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        r0_next       = r0_reg;
        c0_next       = c0_reg;
        ts_next       = ts_reg;
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        addr_next     = addr_reg;
        base_next     = base_reg;
        filled_next   = filled_reg;
        in_store_next = in_store_reg;
        rd_pend_next  = 1'b0;
        // read data lands in the cycle after the address, so count on the pending flag
        cnt_next      = cnt_reg + CNT_W'(rd_pend_reg && (ram_rdata == '0));
        load_out      = 1'b0;
        m_pix_next    = m_pix_reg;
        m_tiles_next  = m_tiles_reg;
        ram_we        = 1'b0;
        ram_waddr     = addr_reg;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = addr_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    priority case (s_command)
                        CMD_WRITE: begin
                            ram_we       = in_store;
                            ram_waddr    = pix_addr;
                            ram_wdata    = s_pixel_in;
                            load_out     = 1'b1;
                            m_pix_next   = '0;
                            m_tiles_next = '0;
                        end
                        CMD_READ: begin
                            ram_re        = 1'b1;
                            ram_raddr     = pix_addr;
                            in_store_next = in_store;
                        end
                        CMD_RUN: begin
                            ts_next     = ts_sat;
                            rows_next   = rows_sat;
                            cols_next   = cols_sat;
                            r0_next     = ORG_W'(1);
                            c0_next     = ORG_W'(1);
                            filled_next = '0;
                        end
                        default: begin
                            load_out     = 1'b1;
                            m_pix_next   = '0;
                            m_tiles_next = '0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                load_out     = 1'b1;
                m_pix_next   = in_store_reg ? ram_rdata : '0;
                m_tiles_next = '0;
            end
            ST_TILE: begin
                if (!row_end) begin
                    if (col_end) begin
                        r0_next = ORG_W'(32'(r0_reg) + 32'(ts_reg));
                        c0_next = ORG_W'(1);
                    end else begin
                        addr_next = tile_addr;
                        base_next = tile_addr;
                        i_next    = '0;
                        j_next    = '0;
                        cnt_next  = '0;
                    end
                end
            end
            ST_COUNT: begin
                ram_re       = 1'b1;
                rd_pend_next = 1'b1;
                i_next       = walk_i;
                j_next       = walk_j;
                addr_next    = walk_addr;
            end
            ST_DRAIN: begin
            end
            ST_DECIDE: begin
                if (fill_hit) begin
                    addr_next = base_reg;
                    i_next    = '0;
                    j_next    = '0;
                    if (filled_reg != TILES_MAX) begin
                        filled_next = filled_reg + 1'b1;
                    end
                end else begin
                    c0_next = ORG_W'(32'(c0_reg) + 32'(ts_reg));
                end
            end
            ST_FILL: begin
                ram_we    = 1'b1;
                i_next    = walk_i;
                j_next    = walk_j;
                addr_next = walk_addr;
                if (walk_last) begin
                    c0_next = ORG_W'(32'(c0_reg) + 32'(ts_reg));
                end
            end
            ST_DONE: begin
                load_out     = 1'b1;
                m_pix_next   = '0;
                m_tiles_next = filled_reg;
            end
            default: begin
            end
        endcase
    end

    // a new beat overrides the one taken at the same edge
    assign m_valid_next = load_out ? 1'b1 : (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        r0_reg       <= r0_next;
        c0_reg       <= c0_next;
        ts_reg       <= ts_next;
        rows_reg     <= rows_next;
        cols_reg     <= cols_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        addr_reg     <= addr_next;
        base_reg     <= base_next;
        cnt_reg      <= cnt_next;
        filled_reg   <= filled_next;
        in_store_reg <= in_store_next;
        m_pix_reg    <= m_pix_next;
        m_tiles_reg  <= m_tiles_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_out    = m_pix_reg;
    assign m_tiles_filled = m_tiles_reg;

    `TDBF_ASSERT_IMPL(a_busy_not_ready, state_reg != ST_IDLE, !s_ready, "ready while busy")
    `TDBF_ASSERT_IMPL(a_slot_free, (state_reg == ST_READ) || (state_reg == ST_DONE), !m_valid_reg, "result lands on a full output register")
    `TDBF_ASSERT_IMPL(a_count_bound, state_reg == ST_DECIDE, 32'(cnt_reg) <= 32'(ts_reg) * 32'(ts_reg), "black count exceeds tile area")
    `TDBF_ASSERT_NEXT(a_fill_from_decide, (state_reg == ST_DECIDE) && fill_hit, (state_reg == ST_FILL) && (addr_reg == base_reg), "fill does not start at tile origin")

endmodule

@@ dv/tb_top.sv @@
// testbench for tile_density_black_fill: pixel writes, reads and tile fill runs
// checked beat by beat against an in-bench frame predictor
// depends on tdbf_pkg and the tile_density_black_fill rtl
module tb_top;
    import tdbf_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    // must outlast the slowest run, a walk over one-pixel tiles
    localparam int QUIET_LIMIT = 20000;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_out;
        logic [TILES_W-1:0] tiles_filled;
    } result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_command = CMD_WRITE;
    logic [COORD_W-1:0] s_row = '0;
    logic [COORD_W-1:0] s_col = '0;
    logic [PIX_W-1:0]   s_pixel_in = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [PIX_W-1:0]   m_pixel_out;
    logic [TILES_W-1:0] m_tiles_filled;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // predictor state: frame copy, written map, register copy
    bit [PIX_W-1:0] pix_mem [0:255][0:255];
    bit             pix_written [0:255][0:255];
    logic [15:0]    written_spots [$];
    cfg_t           model_cfg;
    result_t        due_results [$];
    result_t        want;

    int mismatch_count = 0;
    int quiet_cycles = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int zero_pct = 50;

    tile_density_black_fill uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_row          (s_row),
        .s_col          (s_col),
        .s_pixel_in     (s_pixel_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_out    (m_pixel_out),
        .m_tiles_filled (m_tiles_filled),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int eff_rows();
        return (model_cfg.frame_rows > 256) ? 256 : int'(model_cfg.frame_rows);
    endfunction

    function automatic int eff_cols();
        return (model_cfg.frame_cols > 256) ? 256 : int'(model_cfg.frame_cols);
    endfunction

    function automatic int eff_tile();
        return (model_cfg.tile_size > 16) ? 16 : int'(model_cfg.tile_size);
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        if ($urandom_range(99) < zero_pct)
            return '0;
        return PIX_W'($urandom_range(1, 255));
    endfunction

    // updates the frame copy and returns the beat the command should produce
    function automatic result_t apply_to_frame(logic [1:0] cmd, logic [7:0] row,
                                               logic [7:0] col, logic [7:0] pix);
        result_t res;
        int rows, cols, ts, r, c, rr, cc, n;
        res.pixel_out = '0;
        res.tiles_filled = '0;
        rows = eff_rows();
        cols = eff_cols();
        ts = eff_tile();
        case (cmd)
            CMD_WRITE: pix_mem[row][col] = pix;
            CMD_READ: res.pixel_out = pix_mem[row][col];
            CMD_RUN: begin
                if (ts != 0) begin
                    for (r = 1; r + ts < rows; r += ts) begin
                        for (c = 1; c + ts < cols; c += ts) begin
                            n = 0;
                            for (rr = r; rr < r + ts; rr++)
                                for (cc = c; cc < c + ts; cc++)
                                    if (pix_mem[rr][cc] == 0)
                                        n++;
                            if (n >= int'(model_cfg.fill_threshold)) begin
                                for (rr = r; rr < r + ts; rr++)
                                    for (cc = c; cc < c + ts; cc++)
                                        pix_mem[rr][cc] = '0;
                                if (res.tiles_filled != TILES_MAX)
                                    res.tiles_filled = res.tiles_filled + 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // called just after aclk rises; leaves s_valid high after the beat is taken
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] row,
                             input logic [7:0] col, input logic [7:0] pix);
        result_t res;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_row <= row;
        s_col <= col;
        s_pixel_in <= pix;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (cmd == CMD_WRITE && !pix_written[row][col]) begin
            pix_written[row][col] = 1'b1;
            written_spots = {written_spots, {row, col}};
        end
        res = apply_to_frame(cmd, row, col, pix);
        due_results = {due_results, res};
    endtask

    task automatic idle_until_drained();
        s_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // psel stays high between back-to-back writes
    task automatic apb_write(input logic [1:0] reg_sel, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic program_config(input int rows, input int cols, input int ts,
                                  input int thr);
        apb_write(REG_FRAME_ROWS, rows);
        apb_write(REG_FRAME_COLS, cols);
        apb_write(REG_TILE_SIZE, ts);
        apb_write(REG_FILL_THR, thr);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model_cfg.frame_rows = rows[LIM_W-1:0];
        model_cfg.frame_cols = cols[LIM_W-1:0];
        model_cfg.tile_size = ts[TSIZE_W-1:0];
        model_cfg.fill_threshold = thr[THR_W-1:0];
    endtask

    // a run reads every pixel of every examined tile, so none may be unwritten
    task automatic prepare_run_region();
        int rows, cols, ts, r, c;
        rows = eff_rows();
        cols = eff_cols();
        ts = eff_tile();
        if (ts != 0) begin
            for (r = 1; r < rows; r++)
                for (c = 1; c < cols; c++)
                    if (((r - 1) / ts * ts + ts + 1 < rows) &&
                        ((c - 1) / ts * ts + ts + 1 < cols) && !pix_written[r][c])
                        send_item(CMD_WRITE, 8'(r), 8'(c), random_pixel());
        end
    endtask

    task automatic run_fill();
        prepare_run_region();
        send_item(CMD_RUN, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    endtask

    task automatic read_written_spot();
        logic [15:0] spot;
        spot = written_spots[$urandom_range(written_spots.size() - 1)];
        send_item(CMD_READ, spot[15:8], spot[7:0], 8'($urandom_range(255)));
    endtask

    task automatic pick_random_config();
        int sel, rows, cols, ts, thr;
        sel = $urandom_range(9);
        zero_pct = $urandom_range(100);
        if (sel == 0) begin
            // no tile fits
            rows = $urandom_range(1, 2);
            cols = $urandom_range(1, 24);
            ts = $urandom_range(31);
            thr = $urandom_range(511);
        end else if (sel == 1) begin
            // oversized tile saturates to the maximum
            rows = $urandom_range(17, 20);
            cols = $urandom_range(17, 20);
            ts = $urandom_range(16, 31);
            thr = $urandom_range(1) ? 256 : $urandom_range(256);
            zero_pct = $urandom_range(90, 100);
        end else begin
            rows = $urandom_range(3, 24);
            cols = $urandom_range(3, 24);
            ts = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
            thr = ($urandom_range(9) == 0) ? 511 : $urandom_range(ts * ts + 1);
        end
        program_config(rows, cols, ts, thr);
    endtask

    task automatic test_pixel_access();
        tx_idle_pct = 9;
        rx_idle_pct = 80;
        send_item(CMD_WRITE, 8'd0, 8'd0, 8'h00);
        send_item(CMD_WRITE, 8'd255, 8'd255, 8'hff);
        send_item(CMD_WRITE, 8'd170, 8'd85, 8'haa);
        send_item(CMD_WRITE, 8'd85, 8'd170, 8'h55);
        send_item(CMD_WRITE, 8'd0, 8'd255, 8'h0f);
        send_item(CMD_WRITE, 8'd255, 8'd0, 8'hf0);
        send_item(CMD_READ, 8'd0, 8'd0, 8'hff);
        send_item(CMD_READ, 8'd255, 8'd255, 8'h00);
        send_item(CMD_READ, 8'd170, 8'd85, 8'h00);
        send_item(CMD_READ, 8'd85, 8'd170, 8'h00);
        send_item(CMD_READ, 8'd0, 8'd255, 8'h00);
        send_item(CMD_READ, 8'd255, 8'd0, 8'h00);
        send_item(CMD_WRITE, 8'd0, 8'd0, 8'h81);
        send_item(CMD_READ, 8'd0, 8'd0, 8'h00);
        // unused command must not touch the frame
        send_item(CMD_UNUSED, 8'd255, 8'd255, 8'h00);
        send_item(CMD_UNUSED, 8'd0, 8'd0, 8'hff);
        send_item(CMD_READ, 8'd255, 8'd255, 8'h00);
        send_item(CMD_READ, 8'd0, 8'd0, 8'h00);
    endtask

    task automatic test_tile_special_cases();
        int r, c;
        idle_until_drained();
        program_config(6, 6, 2, 2);
        // zeros on the diagonal: two tiles reach the threshold, two stay clear
        for (r = 1; r <= 4; r++)
            for (c = 1; c <= 4; c++)
                send_item(CMD_WRITE, 8'(r), 8'(c), (r == c) ? 8'd0 : 8'd200);
        send_item(CMD_RUN, 8'd0, 8'd0, 8'd0);
        send_item(CMD_READ, 8'd2, 8'd1, 8'd0);
        send_item(CMD_READ, 8'd1, 8'd3, 8'd0);
        idle_until_drained();
        program_config(6, 6, 2, 0);
        send_item(CMD_RUN, 8'd0, 8'd0, 8'd0);
        send_item(CMD_READ, 8'd1, 8'd3, 8'd0);
        idle_until_drained();
        program_config(6, 6, 2, 5);
        send_item(CMD_RUN, 8'd0, 8'd0, 8'd0);
        idle_until_drained();
        program_config(256, 256, 0, 1);
        send_item(CMD_RUN, 8'd0, 8'd0, 8'd0);
        idle_until_drained();
        program_config(1, 1, 1, 0);
        send_item(CMD_RUN, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_config_extremes();
        int r, c;
        tx_idle_pct = 80;
        rx_idle_pct = 9;
        idle_until_drained();
        zero_pct = 50;
        program_config(511, 3, 1, $urandom_range(1));
        run_fill();
        send_item(CMD_READ, 8'd254, 8'd1, 8'd0);
        idle_until_drained();
        program_config(3, 256, 1, 1);
        run_fill();
        send_item(CMD_READ, 8'd1, 8'd254, 8'd0);
        idle_until_drained();
        program_config(18, 18, 31, 256);
        for (r = 1; r <= 16; r++)
            for (c = 1; c <= 16; c++)
                send_item(CMD_WRITE, 8'(r), 8'(c), 8'd0);
        send_item(CMD_RUN, 8'd0, 8'd0, 8'd0);
        idle_until_drained();
        program_config(18, 18, 16, 511);
        send_item(CMD_RUN, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        int done_items, seg_left, pick;
        logic [7:0] rr, cc;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        done_items = 0;
        while (done_items < n_items) begin
            idle_until_drained();
            pick_random_config();
            seg_left = $urandom_range(40, 110);
            while (seg_left > 0 && done_items < n_items) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    rr = 8'(($urandom_range(9) < 7) ? $urandom_range(eff_rows() - 1)
                                                    : $urandom_range(255));
                    cc = 8'(($urandom_range(9) < 7) ? $urandom_range(eff_cols() - 1)
                                                    : $urandom_range(255));
                    send_item(CMD_WRITE, rr, cc, random_pixel());
                end else if (pick < 88) begin
                    rr = 8'($urandom_range(eff_rows() - 1));
                    cc = 8'($urandom_range(eff_cols() - 1));
                    if (pix_written[rr][cc] && $urandom_range(1) == 0)
                        send_item(CMD_READ, rr, cc, 8'($urandom_range(255)));
                    else
                        read_written_spot();
                end else if (pick < 97) begin
                    run_fill();
                end else begin
                    send_item(CMD_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
                end
                if (pick < 97) begin
                    seg_left--;
                    done_items++;
                end
            end
        end
    endtask

    task automatic test_full_height_fill();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        idle_until_drained();
        zero_pct = 30;
        // a full-height strip of one-pixel tiles, every one filled
        program_config(256, 3, 1, 0);
        run_fill();
        send_item(CMD_READ, 8'd200, 8'd1, 8'd0);
        send_item(CMD_RUN, 8'd0, 8'd0, 8'd0);
    endtask

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("result beat with nothing outstanding");
                mismatch_count++;
            end else begin
                want = due_results.pop_front();
                if (m_pixel_out !== want.pixel_out) begin
                    $error("pixel_out: expected %0d, got %0d", want.pixel_out, m_pixel_out);
                    mismatch_count++;
                end
                if (m_tiles_filled !== want.tiles_filled) begin
                    $error("tiles_filled: expected %0d, got %0d", want.tiles_filled,
                           m_tiles_filled);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        model_cfg.frame_rows = RST_FRAME_ROWS;
        model_cfg.frame_cols = RST_FRAME_COLS;
        model_cfg.tile_size = RST_TILE_SIZE;
        model_cfg.fill_threshold = RST_FILL_THR;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_pixel_access();
        test_tile_special_cases();
        test_config_extremes();
        test_random_traffic(100, 9, 80);
        test_random_traffic(100, 80, 9);
        test_random_traffic(100, 0, 0);
        test_full_height_fill();
        idle_until_drained();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
